// File: rtl/core/asa_pkg.sv
// Shared types and constants for the aging slot allocator.
// Used by every module under rtl/core; depends on nothing else.
package asa_pkg;

   localparam int VALUE_W = 32;
   localparam int AGE_W   = 16;

   localparam logic [AGE_W-1:0] AGE_MAX = '1;

   // Request mode codes.
   localparam logic [1:0] MODE_PUSH  = 2'd0;
   localparam logic [1:0] MODE_WATCH = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]                mode;
      logic signed [VALUE_W-1:0] push_value;
      logic [4:0]                slot_index;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [4:0]                result_index;
      logic signed [VALUE_W-1:0] result_value;
   } rsp_word_type;

   // Update applied by the age count unit; the increment and decrement act on the count last read.
   typedef enum logic [1:0] {
      AGE_CLEAR,
      AGE_SET_ONE,
      AGE_INC,
      AGE_DEC
   } age_op_type;

   typedef struct packed {
      logic       rd_en;
      logic       wr_en;
      age_op_type op;
   } age_ctl_type;

   typedef struct packed {
      logic is_free;
   } age_stat_type;

endpackage

// File: rtl/core/aging_slot_allocator.sv
// Top level of the aging slot allocator: sequencer, free pointer and response register.
// Depends on asa_pkg, asa_age_store and asa_value_store.
//
// The allocator keeps SLOTS slots, each with a 32-bit value and a 16-bit age count held in
// two single-port-read, single-port-write memories; a count of zero marks a free slot. A
// push word scans the counts cyclically from the free pointer, one slot per cycle, stores
// the value in the first free slot with a count of one, and carries on in the same pass to
// find the next free slot, which becomes the new pointer. A watch word reads one slot and
// raises its count if it is nonzero, saturating at the maximum; a tick word walks every
// slot and lowers each nonzero count by one. The block handles one request word at a
// time: a push or a tick reads one count per cycle through the count memory's single
// read port, a watch of an index beyond the table skips the memory read, and the unused
// mode goes straight to the response. A push stops early once the next free slot has
// been found. After reset the count memory is cleared in a pass over every slot, during
// which req_ready stays low.
// Finished response words wait in an output register, so a new request word may be
// accepted while the previous response is still held by a stalled consumer.
module aging_slot_allocator #(
   parameter int SLOTS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  asa_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output asa_pkg::rsp_word_type rsp_word
);
   import asa_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(SLOTS);
   localparam logic [CNT_W-1:0] LAST_CHECK = CNT_W'(SLOTS - 1);
   localparam logic [31:0]      SLOTS_U    = 32'(SLOTS);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PUSH,
      ST_WATCH_RD,
      ST_WATCH_CHK,
      ST_TICK,
      ST_FINISH
   } state_type;

   state_type    state_ff, state_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic [IDX_W-1:0] issue_ptr_ff, issue_ptr_in;
   logic [CNT_W-1:0] issue_cnt_ff, issue_cnt_in;
   logic             chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0] chk_addr_ff, chk_addr_in;
   logic [CNT_W-1:0] chk_cnt_ff, chk_cnt_in;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   req_word_type     req_ff, req_in;
   rsp_word_type     res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_word_type     rsp_word_ff, rsp_word_in;

   age_ctl_type      age_ctl;
   age_stat_type     age_stat;
   logic [IDX_W-1:0] age_rd_addr;
   logic [IDX_W-1:0] age_wr_addr;
   logic             val_wr_en;
   logic             val_rd_en;
   logic signed [VALUE_W-1:0] val_rd_data;

   logic [IDX_W+4:0] watch_wide;
   logic [IDX_W-1:0] watch_addr;
   logic             watch_ok;
   logic             issue_more;
   logic             last_check;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
      return (a == LAST_SLOT) ? '0 : a + 1'b1;
   endfunction

   // The response index is the slot number taken modulo 32.
   function automatic logic [4:0] index5(input logic [IDX_W-1:0] a);
      logic [IDX_W+4:0] wide;
      wide = {5'b0, a};
      return wide[4:0];
   endfunction

   // A watch of an index beyond the table is answered as an empty slot.
   assign watch_wide = {{IDX_W{1'b0}}, req_ff.slot_index};
   assign watch_addr = watch_wide[IDX_W-1:0];
   assign watch_ok   = ({27'b0, req_ff.slot_index} < SLOTS_U);
   assign issue_more = (issue_cnt_ff != SLOT_COUNT);
   assign last_check = (chk_cnt_ff == LAST_CHECK);

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      issue_ptr_in = issue_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      chk_valid_in = 1'b0;
      chk_addr_in  = chk_addr_ff;
      chk_cnt_in   = chk_cnt_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;

      age_ctl      = '{rd_en: 1'b0, wr_en: 1'b0, op: AGE_CLEAR};
      age_rd_addr  = issue_ptr_ff;
      age_wr_addr  = chk_addr_ff;
      val_wr_en    = 1'b0;
      val_rd_en    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            // Zero one count per cycle so that every slot starts free.
            age_ctl.wr_en = 1'b1;
            age_ctl.op    = AGE_CLEAR;
            age_wr_addr   = issue_ptr_ff;
            issue_ptr_in  = wrap_inc(issue_ptr_ff);
            if (issue_ptr_ff == LAST_SLOT) begin
               issue_ptr_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_word;
               res_in       = '0;
               issue_ptr_in = (req_word.mode == MODE_PUSH) ? ptr_ff : '0;
               issue_cnt_in = '0;
               chk_cnt_in   = '0;
               found_in     = 1'b0;
               case (req_word.mode)
                  MODE_PUSH:  state_in = ST_PUSH;
                  MODE_WATCH: state_in = ST_WATCH_RD;
                  MODE_TICK:  state_in = ST_TICK;
                  default:    state_in = ST_FINISH;
               endcase
            end
         end
         ST_PUSH, ST_TICK: begin
            // Each read is issued in the cycle before the check of its returned count.
            if (issue_more) begin
               age_ctl.rd_en = 1'b1;
               issue_ptr_in  = wrap_inc(issue_ptr_ff);
               issue_cnt_in  = issue_cnt_ff + 1'b1;
               chk_valid_in  = 1'b1;
               chk_addr_in   = issue_ptr_ff;
            end
            if (chk_valid_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               if (state_ff == ST_TICK) begin
                  age_ctl.wr_en = 1'b1;
                  age_ctl.op    = AGE_DEC;
                  if (last_check) begin
                     state_in = ST_FINISH;
                  end
               end else if (!found_ff) begin
                  if (age_stat.is_free) begin
                     // First free slot: claim it and keep scanning for the next one.
                     found_in            = 1'b1;
                     slot_in             = chk_addr_ff;
                     age_ctl.wr_en       = 1'b1;
                     age_ctl.op          = AGE_SET_ONE;
                     val_wr_en           = 1'b1;
                     res_in.result_index = index5(chk_addr_ff);
                     if (last_check) begin
                        ptr_in   = wrap_inc(chk_addr_ff);
                        state_in = ST_FINISH;
                     end
                  end else if (last_check) begin
                     res_in.status = STATUS_FULL;
                     state_in      = ST_FINISH;
                  end
               end else if (age_stat.is_free) begin
                  ptr_in   = chk_addr_ff;
                  state_in = ST_FINISH;
               end else if (last_check) begin
                  // No other free slot: the pointer moves just past the slot written.
                  ptr_in   = wrap_inc(slot_ff);
                  state_in = ST_FINISH;
               end
            end
         end
         ST_WATCH_RD: begin
            if (watch_ok) begin
               age_ctl.rd_en = 1'b1;
               age_rd_addr   = watch_addr;
               val_rd_en     = 1'b1;
               state_in      = ST_WATCH_CHK;
            end else begin
               res_in.status = STATUS_EMPTY;
               state_in      = ST_FINISH;
            end
         end
         ST_WATCH_CHK: begin
            if (age_stat.is_free) begin
               res_in.status = STATUS_EMPTY;
            end else begin
               age_ctl.wr_en       = 1'b1;
               age_ctl.op          = AGE_INC;
               age_wr_addr         = watch_addr;
               res_in.result_value = val_rd_data;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         issue_ptr_ff <= '0;
         issue_cnt_ff <= '0;
         chk_valid_ff <= 1'b0;
         chk_cnt_ff   <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         issue_ptr_ff <= issue_ptr_in;
         issue_cnt_ff <= issue_cnt_in;
         chk_valid_ff <= chk_valid_in;
         chk_cnt_ff   <= chk_cnt_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      chk_addr_ff <= chk_addr_in;
      slot_ff     <= slot_in;
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_word_ff <= rsp_word_in;
   end

   asa_age_store #(
      .SLOTS (SLOTS)
   ) u_age_store (
      .clock   (clock),
      .ctl     (age_ctl),
      .rd_addr (age_rd_addr),
      .wr_addr (age_wr_addr),
      .stat    (age_stat)
   );

   asa_value_store #(
      .SLOTS (SLOTS)
   ) u_value_store (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (chk_addr_ff),
      .wr_data (req_ff.push_value),
      .rd_en   (val_rd_en),
      .rd_addr (watch_addr),
      .rd_data (val_rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// File: rtl/core/asa_age_store.sv
// Age count memory of the aging slot allocator with its shared count update unit.
// Depends on asa_pkg.
module asa_age_store #(
   parameter int SLOTS = 32
) (
   input  logic                       clock,
   input  asa_pkg::age_ctl_type       ctl,
   input  logic [$clog2(SLOTS)-1:0]   rd_addr,
   input  logic [$clog2(SLOTS)-1:0]   wr_addr,
   output asa_pkg::age_stat_type      stat
);
   import asa_pkg::*;

   logic [AGE_W-1:0] counts_ff [SLOTS];
   logic [AGE_W-1:0] rd_data_ff;
   logic [AGE_W-1:0] wr_data;
   logic [AGE_W-1:0] delta;
   logic             hold;

   // One incrementer serves both the watch increment and the tick decrement;
   // it holds at the saturation limits.
   always_comb begin
      delta = (ctl.op == AGE_INC) ? AGE_W'(1) : '1;
      hold  = ((ctl.op == AGE_INC) && (rd_data_ff == AGE_MAX)) ||
              ((ctl.op == AGE_DEC) && (rd_data_ff == '0));
      case (ctl.op)
         AGE_CLEAR:   wr_data = '0;
         AGE_SET_ONE: wr_data = AGE_W'(1);
         AGE_INC,
         AGE_DEC:     wr_data = hold ? rd_data_ff : rd_data_ff + delta;
         default:     wr_data = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         counts_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= counts_ff[rd_addr];
      end
   end

   assign stat.is_free = (rd_data_ff == '0);

endmodule

// File: rtl/core/asa_value_store.sv
// Slot value memory of the aging slot allocator.
// Depends on asa_pkg.
module asa_value_store #(
   parameter int SLOTS = 32
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [$clog2(SLOTS)-1:0]           wr_addr,
   input  logic signed [asa_pkg::VALUE_W-1:0] wr_data,
   input  logic                               rd_en,
   input  logic [$clog2(SLOTS)-1:0]           rd_addr,
   output logic signed [asa_pkg::VALUE_W-1:0] rd_data
);
   import asa_pkg::*;

   logic signed [VALUE_W-1:0] values_ff [SLOTS];
   logic signed [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         values_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= values_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
